FILE: rtl/bvtf_pkg.sv
package bvtf_pkg;

    // Bus and memory geometry.
    localparam int unsigned BUS_ADDR_W  = 16;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned WORD_IDX_W  = 12;               // byte pairs in one bank
    localparam int unsigned RAM_ADDR_W  = WORD_IDX_W + 1;   // bank bit on top
    localparam int unsigned COLOR_W     = 2;

    localparam logic [BUS_ADDR_W-1:0] BANK_REG_ADDR = 16'hFF4F;
    localparam logic [2:0]            VRAM_PREFIX   = 3'b100;  // 0x8000-0x9FFF
    localparam logic [BYTE_W-1:0]     BYTE_ALL_ONES = 8'hFF;
    localparam logic [BYTE_W-2:0]     BANK_REG_PAD  = 7'h7F;
    localparam logic [RAM_ADDR_W-1:0] CLR_LAST      = '1;

    // Operation codes.
    localparam logic [1:0] OP_BUS_READ  = 2'd0;
    localparam logic [1:0] OP_BUS_WRITE = 2'd1;
    localparam logic [1:0] OP_BG_FETCH  = 2'd2;
    localparam logic [1:0] OP_OBJ_FETCH = 2'd3;

    // Where a result comes from.
    typedef enum logic [1:0] {
        SRC_FIXED,
        SRC_BYTE,
        SRC_PIXEL
    } t_src;

    typedef struct packed {
        logic [RAM_ADDR_W-1:0] ram_addr;
        logic                  re;
        logic                  we_even;
        logic                  we_odd;
        logic                  bank_we;
        t_src                  src;
        logic [BYTE_W-1:0]     fixed_data;
        logic                  odd_sel;
    } t_req;

endpackage

FILE: rtl/bvtf_item_if.sv
interface bvtf_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [15:0] address;
    logic [7:0] write_data;
    logic       locked;
    logic [7:0] tile_id;
    logic       unsigned_addressing;
    logic       fetch_bank;
    logic       double_height;
    logic [2:0] pixel_x;
    logic [3:0] pixel_y;

    modport source (
        output valid, operation, address, write_data, locked, tile_id,
               unsigned_addressing, fetch_bank, double_height, pixel_x, pixel_y,
        input  ready
    );
    modport sink (
        input  valid, operation, address, write_data, locked, tile_id,
               unsigned_addressing, fetch_bank, double_height, pixel_x, pixel_y,
        output ready
    );
endinterface

FILE: rtl/bvtf_result_if.sv
interface bvtf_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [1:0] pixel_color;

    modport source (output valid, read_data, pixel_color, input ready);
    modport sink   (input valid, read_data, pixel_color, output ready);
endinterface

FILE: rtl/bvtf_cfg_if.sv
interface bvtf_cfg_if;
    logic valid;
    logic ready;
    logic color_mode;

    modport source (output valid, color_mode, input ready);
    modport sink   (input valid, color_mode, output ready);
endinterface

FILE: rtl/bvtf_byte_ram.sv
module bvtf_byte_ram #(
    parameter int unsigned ADDR_W = bvtf_pkg::RAM_ADDR_W,
    parameter int unsigned DATA_W = bvtf_pkg::BYTE_W
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/bvtf_req_decode.sv
module bvtf_req_decode (
    input  logic [1:0]          i_operation,
    input  logic [15:0]         i_address,
    input  logic                i_locked,
    input  logic [7:0]          i_tile_id,
    input  logic                i_unsigned_addressing,
    input  logic                i_fetch_bank,
    input  logic                i_double_height,
    input  logic [3:0]          i_pixel_y,
    input  logic                i_color_mode,
    input  logic                i_bank_select,
    output bvtf_pkg::t_req      o_req
);

    logic                                is_reg;
    logic                                is_vram;
    logic                                cpu_bank;
    logic [7:0]                          obj_id;
    logic [bvtf_pkg::WORD_IDX_W-1:0]     bg_word;
    logic [bvtf_pkg::WORD_IDX_W-1:0]     obj_word;

    assign is_reg   = i_color_mode && (i_address == bvtf_pkg::BANK_REG_ADDR);
    assign is_vram  = (i_address[15:13] == bvtf_pkg::VRAM_PREFIX);
    assign cpu_bank = i_color_mode & i_bank_select;

    // Signed addressing puts tile 0 at 0x9000, so in byte-pair units the
    // sign-extended id plus 0x800 is just the id with its top bit inverted.
    assign bg_word = i_unsigned_addressing ? {1'b0, i_tile_id, i_pixel_y[2:0]}
                                           : {~i_tile_id[7], i_tile_id, i_pixel_y[2:0]};

    // Object rows 8-15 carry into the next tile; the sum stays inside the bank.
    assign obj_id   = i_double_height ? {i_tile_id[7:1], 1'b0} : i_tile_id;
    assign obj_word = {1'b0, obj_id, 3'b000} + {8'h00, i_pixel_y};

    always_comb begin
        o_req            = '0;
        o_req.src        = bvtf_pkg::SRC_FIXED;
        o_req.fixed_data = '0;
        unique case (i_operation)
            bvtf_pkg::OP_BUS_READ: begin
                if (is_reg) begin
                    o_req.fixed_data = {bvtf_pkg::BANK_REG_PAD, i_bank_select};
                end else if (is_vram && !i_locked) begin
                    o_req.src      = bvtf_pkg::SRC_BYTE;
                    o_req.re       = 1'b1;
                    o_req.ram_addr = {cpu_bank, i_address[12:1]};
                    o_req.odd_sel  = i_address[0];
                end else begin
                    o_req.fixed_data = bvtf_pkg::BYTE_ALL_ONES;
                end
            end
            bvtf_pkg::OP_BUS_WRITE: begin
                if (is_reg) begin
                    o_req.bank_we = 1'b1;
                end else if (is_vram && !i_locked) begin
                    o_req.ram_addr = {cpu_bank, i_address[12:1]};
                    o_req.we_even  = ~i_address[0];
                    o_req.we_odd   = i_address[0];
                end
            end
            bvtf_pkg::OP_BG_FETCH: begin
                o_req.src      = bvtf_pkg::SRC_PIXEL;
                o_req.re       = 1'b1;
                o_req.ram_addr = {i_fetch_bank, bg_word};
            end
            bvtf_pkg::OP_OBJ_FETCH: begin
                o_req.src      = bvtf_pkg::SRC_PIXEL;
                o_req.re       = 1'b1;
                o_req.ram_addr = {i_fetch_bank, obj_word};
            end
            default: begin
                o_req.src = bvtf_pkg::SRC_FIXED;
            end
        endcase
    end

endmodule

FILE: rtl/banked_video_ram_tile_fetch_core.sv
// Each item passes through the read stage and then the result register.
// Throughput: one item per cycle; outside the clearing pass the item channel stalls only
// while the read stage and the result register are both full and the result is not taken.
// Reset clears the bank select and color mode registers, then a clearing pass
// zeroes the video memory, one byte pair per cycle, with the item channel not
// ready. Configuration transfers are always taken.
module banked_video_ram_tile_fetch_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bvtf_cfg_if.sink              i_cfg,
    bvtf_item_if.sink             i_item,
    bvtf_result_if.source         o_result
);

    bvtf_pkg::t_req                        req;
    logic                                  accept;
    logic                                  s1_adv;

    logic                                  r_color_mode;
    logic                                  r_bank_select;
    logic                                  r_clearing;
    logic [bvtf_pkg::RAM_ADDR_W-1:0]       r_clr_addr;

    logic                                  r_s1_valid;
    bvtf_pkg::t_src                        r_s1_src;
    logic [bvtf_pkg::BYTE_W-1:0]           r_s1_fixed;
    logic                                  r_s1_odd;
    logic [2:0]                            r_s1_px;

    logic                                  r_out_valid;
    logic [bvtf_pkg::BYTE_W-1:0]           r_out_read_data;
    logic [bvtf_pkg::COLOR_W-1:0]          r_out_pixel_color;

    logic [bvtf_pkg::BYTE_W-1:0]           n_read_data;
    logic [bvtf_pkg::COLOR_W-1:0]          n_pixel_color;

    logic [bvtf_pkg::RAM_ADDR_W-1:0]       ram_waddr;
    logic [bvtf_pkg::BYTE_W-1:0]           ram_wdata;
    logic                                  we_even;
    logic                                  we_odd;
    logic                                  ram_re;
    logic [bvtf_pkg::BYTE_W-1:0]           even_rdata;
    logic [bvtf_pkg::BYTE_W-1:0]           odd_rdata;
    logic [2:0]                            bit_idx;

    bvtf_req_decode u_decode (
        .i_operation           (i_item.operation),
        .i_address             (i_item.address),
        .i_locked              (i_item.locked),
        .i_tile_id             (i_item.tile_id),
        .i_unsigned_addressing (i_item.unsigned_addressing),
        .i_fetch_bank          (i_item.fetch_bank),
        .i_double_height       (i_item.double_height),
        .i_pixel_y             (i_item.pixel_y),
        .i_color_mode          (r_color_mode),
        .i_bank_select         (r_bank_select),
        .o_req                 (req)
    );

    assign s1_adv       = !r_out_valid || o_result.ready;
    assign i_item.ready = !r_clearing && (!r_s1_valid || s1_adv);
    assign accept       = i_item.valid && i_item.ready;
    assign i_cfg.ready  = 1'b1;

    // The low plane of a row sits at the even byte and the high plane at the
    // odd byte, so one read of each byte memory gives a whole pixel.
    assign ram_waddr = r_clearing ? r_clr_addr : req.ram_addr;
    assign ram_wdata = r_clearing ? '0 : i_item.write_data;
    assign we_even   = r_clearing || (accept && req.we_even);
    assign we_odd    = r_clearing || (accept && req.we_odd);
    assign ram_re    = accept && req.re;

    bvtf_byte_ram #(
        .ADDR_W (bvtf_pkg::RAM_ADDR_W),
        .DATA_W (bvtf_pkg::BYTE_W)
    ) u_even_ram (
        .i_clk   (i_clk),
        .i_we    (we_even),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (req.ram_addr),
        .o_rdata (even_rdata)
    );

    bvtf_byte_ram #(
        .ADDR_W (bvtf_pkg::RAM_ADDR_W),
        .DATA_W (bvtf_pkg::BYTE_W)
    ) u_odd_ram (
        .i_clk   (i_clk),
        .i_we    (we_odd),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (req.ram_addr),
        .o_rdata (odd_rdata)
    );

    // Column 0 is bit 7.
    assign bit_idx = 3'd7 - r_s1_px;

    always_comb begin
        n_read_data   = '0;
        n_pixel_color = '0;
        case (r_s1_src)
            bvtf_pkg::SRC_FIXED: n_read_data = r_s1_fixed;
            bvtf_pkg::SRC_BYTE:  n_read_data = r_s1_odd ? odd_rdata : even_rdata;
            bvtf_pkg::SRC_PIXEL: n_pixel_color = {odd_rdata[bit_idx], even_rdata[bit_idx]};
            default:             n_read_data = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode  <= 1'b0;
            r_bank_select <= 1'b0;
            r_clearing    <= 1'b1;
            r_clr_addr    <= '0;
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_color_mode <= i_cfg.color_mode;
            end
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == bvtf_pkg::CLR_LAST) begin
                    r_clearing <= 1'b0;
                end
            end
            if (accept && req.bank_we) begin
                r_bank_select <= i_item.write_data[0];
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_src   <= req.src;
            r_s1_fixed <= req.fixed_data;
            r_s1_odd   <= req.odd_sel;
            r_s1_px    <= i_item.pixel_x;
        end
        if (s1_adv && r_s1_valid) begin
            r_out_read_data   <= n_read_data;
            r_out_pixel_color <= n_pixel_color;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.read_data   = r_out_read_data;
    assign o_result.pixel_color = r_out_pixel_color;

`ifndef SYNTHESIS
    a_no_item_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !i_item.ready)
        else $error("item channel ready during the clearing pass");

    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (r_clearing && r_clr_addr == '0))
        else $error("clearing pass did not start after reset");

    a_stage_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |-> !i_item.ready)
        else $error("item taken while the read stage is stalled");

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("transferred item lost before the read stage");
`endif

endmodule
